// ===== design/plac_pkg.sv =====
// Package for the polyline length accumulator.
// Holds field widths, op codes and the stored point format.
// No dependencies.
package plac_pkg;

  localparam int POINTS   = 16384;
  localparam int IDX_W    = 14;
  localparam int OP_W     = 2;
  localparam int COORD_W  = 32;
  localparam int SEG_W    = 48;
  localparam int TOT_W    = 56;
  localparam int RAD_W    = 68;
  localparam int ROOT_W   = 34;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_VISIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               valid;
  } point_t;

  localparam int PT_W = $bits(point_t);

endpackage

// ===== design/plac_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module plac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/plac_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on plac_pkg for widths.
module plac_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [plac_pkg::RAD_W-1:0]  radicand,
  output logic                      done,
  output logic [plac_pkg::ROOT_W-1:0] root
);
  import plac_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  // One digit step: bring down two bits, try subtracting 4r+1
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  // Hold operands and advance one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W - 1);
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= take ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], take};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/polyline_length_accumulator_core.sv =====
// Polyline length accumulator: point table in RAM, 3D distance and root per visit between valid points.
// Load and clear are taken while idle and do not stall. A visit holds the input while
// it passes through read and difference, square, sum, the bit-serial root unit when it
// adds a distance, accumulate, and total when it closes a segment. A result is registered
// once its closing visit reaches total, later while an earlier result waits.
// One request at a time.
// Reset (synchronous, rst_n low) clears sums, flags and the walk; the point table is
// not cleared and holds garbage until loaded.
module polyline_length_accumulator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [plac_pkg::OP_W-1:0]      in_op,
  input  logic [plac_pkg::IDX_W-1:0]     in_point_index,
  input  logic signed [plac_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [plac_pkg::COORD_W-1:0] in_y_coord,
  input  logic signed [plac_pkg::COORD_W-1:0] in_z_coord,
  input  logic                           in_coord_valid,
  input  logic                           in_last_in_segment,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [plac_pkg::SEG_W-1:0]     out_segment_length,
  output logic [plac_pkg::TOT_W-1:0]     out_total_length,
  output logic                           out_length_saturated
);
  import plac_pkg::*;

  localparam int D_W  = COORD_W + 1;
  localparam int SQ_W = 2 * D_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_SQR, ST_SUM, ST_ROOT, ST_ACC, ST_TOT
  } state_t;

  state_t            state_r;
  point_t            prev_r;
  point_t            cur_r;
  point_t            ram_wdata;
  point_t            ram_rdata;
  logic              started_r;
  logic              last_r;
  logic              need_r;
  logic [SEG_W-1:0]  seg_r;
  logic [TOT_W-1:0]  tot_r;
  logic              satf_r;
  logic [ROOT_W-1:0] dist_r;
  logic [D_W-1:0]    dx_r, dy_r, dz_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [RAD_W-1:0]  rad_sum;
  logic              out_valid_r;
  logic [SEG_W-1:0]  out_seg_r;
  logic [TOT_W-1:0]  out_tot_r;
  logic              out_sat_r;
  logic              sq_start;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic              accept;
  logic              ram_we;
  logic              ram_re;
  logic [SEG_W:0]    seg_sum;
  logic [TOT_W:0]    tot_sum;
  logic              out_free;
  logic              out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ram_we   = accept && (in_op == OP_LOAD);
  assign ram_re   = accept && (in_op == OP_VISIT);
  assign ram_wdata = '{x: in_x_coord, y: in_y_coord, z: in_z_coord,
                       valid: in_coord_valid};
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_TOT) && out_free;

  plac_ram #(.WIDTH(PT_W), .DEPTH(POINTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_point_index),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_point_index),
    .rdata (ram_rdata)
  );

  // Feed the squared distance straight into the root unit as it starts
  assign rad_sum  = RAD_W'(sx_r) + RAD_W'(sy_r) + RAD_W'(sz_r);
  assign sq_start = (state_r == ST_SUM) && need_r;

  plac_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (rad_sum),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Saturating adds for segment and total
  assign seg_sum = {1'b0, seg_r} + (SEG_W+1)'(dist_r);
  assign tot_sum = {1'b0, tot_r} + (TOT_W+1)'(seg_r);

  function automatic logic [D_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                             input logic [COORD_W-1:0] b);
    logic signed [D_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[D_W-1] ? D_W'(-d) : D_W'(d);
  endfunction

  // Sequence one request through read, square, root when needed, accumulate and total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      started_r   <= 1'b0;
      seg_r       <= '0;
      tot_r       <= '0;
      satf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            last_r <= in_last_in_segment;
            if (in_op == OP_VISIT) begin
              state_r <= ST_RD;
            end else if (in_op == OP_CLEAR) begin
              tot_r <= '0;
            end
          end
        end
        ST_RD: begin
          cur_r  <= ram_rdata;
          need_r <= started_r && ram_rdata.valid && prev_r.valid;
          dx_r   <= absdiff(prev_r.x, ram_rdata.x);
          dy_r   <= absdiff(prev_r.y, ram_rdata.y);
          dz_r   <= absdiff(prev_r.z, ram_rdata.z);
          dist_r <= '0;
          state_r <= ST_SQR;
        end
        ST_SQR: begin
          sx_r <= dx_r * dx_r;
          sy_r <= dy_r * dy_r;
          sz_r <= dz_r * dz_r;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          state_r <= need_r ? ST_ROOT : ST_ACC;
        end
        ST_ROOT: begin
          if (sq_done) begin
            dist_r  <= sq_root;
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (seg_sum[SEG_W]) begin
            seg_r  <= '1;
            satf_r <= 1'b1;
          end else begin
            seg_r <= seg_sum[SEG_W-1:0];
          end
          prev_r    <= cur_r;
          started_r <= 1'b1;
          state_r   <= last_r ? ST_TOT : ST_IDLE;
        end
        ST_TOT: begin
          if (out_free) begin
            out_seg_r   <= seg_r;
            out_tot_r   <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
            out_sat_r   <= satf_r || tot_sum[TOT_W] || (tot_sum[TOT_W-1:0] == '1);
            tot_r       <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
            seg_r       <= '0;
            satf_r      <= 1'b0;
            started_r   <= 1'b0;
            prev_r      <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_segment_length   = out_seg_r;
  assign out_total_length     = out_tot_r;
  assign out_length_saturated = out_sat_r;

  // A new result appears only out of the total stage
  a_out_from_tot: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_TOT))
    else $error("result raised outside total stage");

  // The root unit finishes only while the sequencer waits for it
  a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ST_ROOT)
    else $error("root done outside wait state");

  // An accepted visit goes to the table read
  a_visit_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_VISIT) |=> state_r == ST_RD)
    else $error("visit did not start table read");

endmodule
